/* rtl/core/thermistor_summary_frame_assert.svh */
// Assertion macros for the thermistor summary frame checker.
`ifndef THERMISTOR_SUMMARY_FRAME_ASSERT_SVH
`define THERMISTOR_SUMMARY_FRAME_ASSERT_SVH

// Checked on every aclk edge outside reset.
`define TSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every aclk edge, reset included.
`define TSF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/core/tsf_pkg.sv */
// Shared types and constants of the thermistor summary frame block.
`default_nettype none

package tsf_pkg;

    // Lane count carried by one item and number of lanes actually used
    localparam int LANES        = 6;
    localparam int SENSOR_COUNT = 6;
    localparam int N_USED       = (SENSOR_COUNT < 1) ? 1 :
                                  ((SENSOR_COUNT > LANES) ? LANES : SENSOR_COUNT);

    // Field widths
    localparam int TEMP_W = 16;
    localparam int FRAC_W = 8;
    localparam int DEG_W  = 8;
    localparam int LANE_W = 3;
    localparam int SUM_W  = TEMP_W + $clog2(LANES + 1);

    // Whole-degree range
    localparam int DEG_MIN = -(1 << (DEG_W - 1));
    localparam int DEG_MAX = (1 << (DEG_W - 1)) - 1;

    // Mean: |sum| >> FRAC_W, then divide by N_USED through a reciprocal
    localparam int WHOLE_W     = SUM_W - FRAC_W;
    localparam int RECIP_SHIFT = 12;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + N_USED - 1) / N_USED;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int MAG_W       = DEG_W + 1;

    // Frame check terms
    localparam int           MODULE_NUMBER = 0;
    localparam logic [7:0]   CHECK_CONST   = 8'h41;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic signed [DEG_W-1:0]  deg_t;
    typedef logic [LANE_W-1:0]        lane_idx_t;

    // Reduction results handed from the merge stage to the mean stage
    typedef struct packed {
        deg_t                    lo;
        deg_t                    hi;
        lane_idx_t               lo_lane;
        lane_idx_t               hi_lane;
        logic signed [SUM_W-1:0] sum;
    } merge_t;

endpackage

`default_nettype wire

/* rtl/core/tsf_lane.sv */
// One sensor lane: Q8.8 reading truncated toward zero to a saturated whole degree.
`default_nettype none

module tsf_lane (
    input  tsf_pkg::temp_t temp,
    output tsf_pkg::deg_t  deg
);

    logic signed [tsf_pkg::DEG_W:0] shifted;
    logic                           round_up;
    logic signed [tsf_pkg::DEG_W:0] whole;

    // Floor shift, then step back toward zero for negative values with a fraction
    always_comb begin
        shifted  = (tsf_pkg::DEG_W + 1)'(temp >>> tsf_pkg::FRAC_W);
        round_up = temp[tsf_pkg::TEMP_W-1] && (temp[tsf_pkg::FRAC_W-1:0] != '0);
        whole    = shifted + $signed({{tsf_pkg::DEG_W{1'b0}}, round_up});
        if (whole < tsf_pkg::DEG_MIN) begin
            deg = tsf_pkg::DEG_W'(tsf_pkg::DEG_MIN);
        end else if (whole > tsf_pkg::DEG_MAX) begin
            deg = tsf_pkg::DEG_W'(tsf_pkg::DEG_MAX);
        end else begin
            deg = whole[tsf_pkg::DEG_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tsf_merge.sv */
// Merge of the lane results: first-lane minimum and maximum, and the exact Q8.8 sum.
`default_nettype none

module tsf_merge (
    input  tsf_pkg::deg_t  deg  [tsf_pkg::LANES],
    input  tsf_pkg::temp_t temp [tsf_pkg::LANES],
    output tsf_pkg::merge_t merged
);

    always_comb begin
        merged         = '0;
        merged.lo      = deg[0];
        merged.hi      = deg[0];
        merged.lo_lane = '0;
        merged.hi_lane = '0;
        merged.sum     = tsf_pkg::SUM_W'(temp[0]);
        // Strict compares keep the earliest lane on a tie
        for (int i = 1; i < tsf_pkg::N_USED; i++) begin
            if (deg[i] < merged.lo) begin
                merged.lo      = deg[i];
                merged.lo_lane = tsf_pkg::LANE_W'(i);
            end
            if (deg[i] > merged.hi) begin
                merged.hi      = deg[i];
                merged.hi_lane = tsf_pkg::LANE_W'(i);
            end
            merged.sum = merged.sum + tsf_pkg::SUM_W'(temp[i]);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tsf_mean.sv */
// Mean of the lanes (truncated toward zero, saturated) and the frame check byte.
`default_nettype none

module tsf_mean (
    input  tsf_pkg::merge_t merged,
    output tsf_pkg::deg_t   mean,
    output logic [7:0]      check
);

    logic                                              sum_neg;
    logic [tsf_pkg::SUM_W-1:0]                         mag;
    logic [tsf_pkg::WHOLE_W-1:0]                       whole;
    logic [tsf_pkg::WHOLE_W+tsf_pkg::RECIP_W-1:0]      prod;
    logic [tsf_pkg::MAG_W-1:0]                         quot;
    logic signed [tsf_pkg::MAG_W:0]                    signed_quot;

    // Divide |sum| by 256 * N: shift out the fraction, multiply by reciprocal
    always_comb begin
        sum_neg = merged.sum[tsf_pkg::SUM_W-1];
        mag     = sum_neg ? tsf_pkg::SUM_W'(-merged.sum) : tsf_pkg::SUM_W'(merged.sum);
        whole   = mag[tsf_pkg::FRAC_W +: tsf_pkg::WHOLE_W];
        prod    = (tsf_pkg::WHOLE_W + tsf_pkg::RECIP_W)'(whole)
                * (tsf_pkg::WHOLE_W + tsf_pkg::RECIP_W)'(tsf_pkg::RECIP);
        quot    = prod[tsf_pkg::RECIP_SHIFT +: tsf_pkg::MAG_W];
        signed_quot = sum_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        if (signed_quot < tsf_pkg::DEG_MIN) begin
            mean = tsf_pkg::DEG_W'(tsf_pkg::DEG_MIN);
        end else if (signed_quot > tsf_pkg::DEG_MAX) begin
            mean = tsf_pkg::DEG_W'(tsf_pkg::DEG_MAX);
        end else begin
            mean = signed_quot[tsf_pkg::DEG_W-1:0];
        end
    end

    // Wrapping byte sum of the frame fields
    always_comb begin
        check = 8'(tsf_pkg::MODULE_NUMBER) + $unsigned(merged.lo) + $unsigned(merged.hi)
              + $unsigned(mean) + 8'(tsf_pkg::N_USED) + 8'(merged.hi_lane)
              + 8'(merged.lo_lane) + tsf_pkg::CHECK_CONST;
    end

endmodule

`default_nettype wire

/* rtl/core/thermistor_summary_frame.sv */
// Thermistor summary frame: three-stage pipeline taking one item per clock except when stalled.
// Each transfer on the s_ channel carries six signed Q8.8 readings; each lane truncates its
// reading toward zero to a whole degree in the first stage, the merge stage finds the lowest
// and highest values (earliest lane wins a tie) and the exact sum, and the last stage forms the
// mean (sum / sensor count, toward zero) and the frame check byte. Results pass through the
// lane, merge and output registers to the m_ channel; the pipeline takes a new item every cycle
// and only stalls when m_ready is low and every stage is occupied. s_ready follows m_ready
// combinationally through the stage occupancy chain. Reset empties the pipeline.
`default_nettype none

module thermistor_summary_frame (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  signed [15:0]    s_temp_lane0,
    input  wire  signed [15:0]    s_temp_lane1,
    input  wire  signed [15:0]    s_temp_lane2,
    input  wire  signed [15:0]    s_temp_lane3,
    input  wire  signed [15:0]    s_temp_lane4,
    input  wire  signed [15:0]    s_temp_lane5,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic signed [7:0]     m_lowest_degrees,
    output logic signed [7:0]     m_highest_degrees,
    output logic signed [7:0]     m_mean_degrees,
    output logic [2:0]            m_lowest_lane,
    output logic [2:0]            m_highest_lane,
    output logic [7:0]            m_frame_check
);

    tsf_pkg::temp_t  temp_in   [tsf_pkg::LANES];
    tsf_pkg::deg_t   deg_comb  [tsf_pkg::LANES];
    tsf_pkg::temp_t  temp_reg  [tsf_pkg::LANES];
    tsf_pkg::deg_t   deg_reg   [tsf_pkg::LANES];
    tsf_pkg::merge_t merge_comb;
    tsf_pkg::merge_t merge_reg;
    tsf_pkg::deg_t   mean_comb;
    logic [7:0]      check_comb;

    logic lane_valid_reg;
    logic merge_valid_reg;
    logic out_valid_reg;
    logic lane_adv;
    logic merge_adv;
    logic out_adv;
    logic out_ready;
    logic merge_ready;

    assign temp_in[0] = s_temp_lane0;
    assign temp_in[1] = s_temp_lane1;
    assign temp_in[2] = s_temp_lane2;
    assign temp_in[3] = s_temp_lane3;
    assign temp_in[4] = s_temp_lane4;
    assign temp_in[5] = s_temp_lane5;

    // Stage occupancy chain: a stage takes data when it is empty or drains this cycle
    assign out_ready   = !out_valid_reg || m_ready;
    assign merge_ready = !merge_valid_reg || out_ready;
    assign s_ready     = !lane_valid_reg || merge_ready;
    assign lane_adv    = s_valid && s_ready;
    assign merge_adv   = lane_valid_reg && merge_ready;
    assign out_adv     = merge_valid_reg && out_ready;

    // Lane conversion
    for (genvar g = 0; g < tsf_pkg::LANES; g++) begin : g_lane
        tsf_lane u_lane (
            .temp (temp_in[g]),
            .deg  (deg_comb[g])
        );
    end

    tsf_merge u_merge (
        .deg    (deg_reg),
        .temp   (temp_reg),
        .merged (merge_comb)
    );

    tsf_mean u_mean (
        .merged (merge_reg),
        .mean   (mean_comb),
        .check  (check_comb)
    );

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_valid_reg  <= 1'b0;
            merge_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                lane_valid_reg <= s_valid;
            end
            if (merge_ready) begin
                merge_valid_reg <= lane_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= merge_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (lane_adv) begin
            temp_reg <= temp_in;
            deg_reg  <= deg_comb;
        end
        if (merge_adv) begin
            merge_reg <= merge_comb;
        end
        if (out_adv) begin
            m_lowest_degrees  <= merge_reg.lo;
            m_highest_degrees <= merge_reg.hi;
            m_mean_degrees    <= mean_comb;
            m_lowest_lane     <= merge_reg.lo_lane;
            m_highest_lane    <= merge_reg.hi_lane;
            m_frame_check     <= check_comb;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/tsf_checker.sv */
// Port-level checker for the thermistor summary frame, bound to the top level.
`default_nettype none

`include "thermistor_summary_frame_assert.svh"

module tsf_checker (
    input wire               aclk,
    input wire               aresetn,
    input wire               m_valid,
    input wire               m_ready,
    input wire signed [7:0]  m_lowest_degrees,
    input wire signed [7:0]  m_highest_degrees,
    input wire signed [7:0]  m_mean_degrees,
    input wire [2:0]         m_lowest_lane,
    input wire [2:0]         m_highest_lane,
    input wire [7:0]         m_frame_check
);

    logic [37:0] shown;
    logic        in_order;
    logic        lanes_ok;
    logic [7:0]  frame_sum;

    // Everything the result channel shows, for the hold check
    assign shown = {m_frame_check, m_mean_degrees, m_lowest_degrees, m_highest_degrees,
                    m_lowest_lane, m_highest_lane};

    // Lowest never above highest, mean between them
    assign in_order = (m_lowest_degrees <= m_highest_degrees)
                   && (m_lowest_degrees <= m_mean_degrees)
                   && (m_mean_degrees <= m_highest_degrees);

    // Lane indices stay within the used sensors
    assign lanes_ok = (m_lowest_lane < tsf_pkg::LANE_W'(tsf_pkg::N_USED))
                   && (m_highest_lane < tsf_pkg::LANE_W'(tsf_pkg::N_USED));

    // Check byte rebuilt from the frame fields shown
    assign frame_sum = 8'(tsf_pkg::MODULE_NUMBER) + 8'(m_lowest_degrees)
                     + 8'(m_highest_degrees) + 8'(m_mean_degrees) + 8'(tsf_pkg::N_USED)
                     + 8'(m_lowest_lane) + 8'(m_highest_lane) + tsf_pkg::CHECK_CONST;

    // Reset empties the pipeline
    `TSF_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

    // A stalled result holds
    `TSF_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(shown), "result changed")

    `TSF_ASSERT(a_order, m_valid |-> in_order, "low/mean/high out of order")

    `TSF_ASSERT(a_lane_range, m_valid |-> lanes_ok, "lane index beyond sensor count")

    `TSF_ASSERT(a_check, m_valid |-> m_frame_check == frame_sum, "frame check mismatch")

endmodule

bind thermistor_summary_frame tsf_checker u_tsf_checker (.*);

`default_nettype wire

/* bench/thermistor_summary_frame_test.sv */
// Self-checking testbench for the thermistor summary frame block.
`timescale 1ns / 100ps

module thermistor_summary_frame_test;

    localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer before giving up
    localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 12;    // pipeline is three deep
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ONE     = 510;
    localparam int PHASE_TWO     = 510;
    localparam int PHASE_THREE   = 513;

    localparam tsf_pkg::temp_t HOT  = 16'sh7FFF;
    localparam tsf_pkg::temp_t COLD = 16'sh8000;

    typedef tsf_pkg::temp_t [0:tsf_pkg::LANES-1] reading_set_t;

    typedef struct packed {
        tsf_pkg::deg_t      lowest;
        tsf_pkg::deg_t      highest;
        tsf_pkg::deg_t      mean;
        tsf_pkg::lane_idx_t lowest_lane;
        tsf_pkg::lane_idx_t highest_lane;
        logic [7:0]         check;
    } summary_t;

    typedef struct packed {
        reading_set_t readings;
        logic         typed;
        summary_t     want;
    } directed_row_t;

    // DUT connections; the driven inputs are known from time zero
    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               m_ready = 1'b0;
    tsf_pkg::temp_t     s_temp_lane0 = '0;
    tsf_pkg::temp_t     s_temp_lane1 = '0;
    tsf_pkg::temp_t     s_temp_lane2 = '0;
    tsf_pkg::temp_t     s_temp_lane3 = '0;
    tsf_pkg::temp_t     s_temp_lane4 = '0;
    tsf_pkg::temp_t     s_temp_lane5 = '0;
    logic               s_ready;
    logic               m_valid;
    tsf_pkg::deg_t      m_lowest_degrees;
    tsf_pkg::deg_t      m_highest_degrees;
    tsf_pkg::deg_t      m_mean_degrees;
    tsf_pkg::lane_idx_t m_lowest_lane;
    tsf_pkg::lane_idx_t m_highest_lane;
    logic [7:0]         m_frame_check;

    summary_t pending_summaries [$];
    int       mismatches    = 0;
    int       quiet_cycles  = 0;
    int       tx_idle_pct   = 0;
    int       rx_idle_pct   = 0;
    int       hold_left     = 0;
    bit       hold_request  = 1'b0;

    // Corner values mixed per lane by the random part
    tsf_pkg::temp_t corner_values [8] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                                          16'sh0001, 16'shFF00, 16'sh0100, 16'shFF01};

    // Directed rows: typed expectations only where obvious, the rest go to the predictor
    directed_row_t directed_rows [17] = '{
        '{'{16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, 1'b1,
          '{8'sd0, 8'sd0, 8'sd0, 3'd0, 3'd0, 8'h47}},
        '{'{HOT, HOT, HOT, HOT, HOT, HOT}, 1'b1,
          '{8'sd127, 8'sd127, 8'sd127, 3'd0, 3'd0, 8'hC4}},
        '{'{COLD, COLD, COLD, COLD, COLD, COLD}, 1'b1,
          '{-8'sd128, -8'sd128, -8'sd128, 3'd0, 3'd0, 8'hC7}},
        // one cold lane among hot ones, and alternating extremes
        '{'{COLD, HOT, HOT, HOT, HOT, HOT}, 1'b0, '0},
        '{'{HOT, COLD, HOT, COLD, HOT, COLD}, 1'b0, '0},
        // truncation toward zero around +-1 degree
        '{'{16'shFF01, 16'sh00FF, 16'shFF00, 16'sh0100, 16'shFEFF, 16'sh0101}, 1'b0, '0},
        // ties: lowest on lanes 2 and 4, highest on lanes 1 and 5
        '{'{16'sh0500, 16'sh0A00, 16'shFD00, 16'sh0700, 16'shFD00, 16'sh0A00}, 1'b0, '0},
        // extremes sitting in the last lane
        '{'{16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0100}, 1'b0, '0},
        '{'{16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'shFF00}, 1'b0, '0},
        // different fractions, same whole degree
        '{'{16'sh0180, 16'sh01FF, 16'sh0100, 16'sh01C0, 16'sh0101, 16'sh0140}, 1'b0, '0},
        // mean just around zero and -1
        '{'{16'shFFFF, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, 1'b0, '0},
        '{'{16'shFF00, 16'shFF00, 16'shFF00, 16'shFF00, 16'shFF00, 16'shFF00}, 1'b0, '0},
        '{'{16'shFEFF, 16'shFF00, 16'shFF00, 16'shFF00, 16'shFF00, 16'shFF00}, 1'b0, '0},
        // bit patterns
        '{'{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA}, 1'b0, '0},
        '{'{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555}, 1'b0, '0},
        '{'{COLD, COLD, COLD, HOT, COLD, COLD}, 1'b0, '0},
        '{'{16'sh0001, 16'sh0002, 16'sh0004, 16'sh0008, 16'sh0010, 16'sh0020}, 1'b0, '0}
    };

    thermistor_summary_frame uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_temp_lane0      (s_temp_lane0),
        .s_temp_lane1      (s_temp_lane1),
        .s_temp_lane2      (s_temp_lane2),
        .s_temp_lane3      (s_temp_lane3),
        .s_temp_lane4      (s_temp_lane4),
        .s_temp_lane5      (s_temp_lane5),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_lowest_degrees  (m_lowest_degrees),
        .m_highest_degrees (m_highest_degrees),
        .m_mean_degrees    (m_mean_degrees),
        .m_lowest_lane     (m_lowest_lane),
        .m_highest_lane    (m_highest_lane),
        .m_frame_check     (m_frame_check)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int clamp_degrees(input int v);
        if (v < tsf_pkg::DEG_MIN) return tsf_pkg::DEG_MIN;
        if (v > tsf_pkg::DEG_MAX) return tsf_pkg::DEG_MAX;
        return v;
    endfunction

    // Min/max with first-lane tie break, truncated mean, and the check byte
    function automatic summary_t summarize_readings(input reading_set_t r);
        summary_t   s;
        int         used;
        int         q;
        int         whole;
        int         total;
        int         lo;
        int         hi;
        int         lo_lane;
        int         hi_lane;
        int         avg;
        logic [7:0] sum8;
        used    = (tsf_pkg::SENSOR_COUNT < 1) ? 1 :
                  ((tsf_pkg::SENSOR_COUNT > tsf_pkg::LANES) ? tsf_pkg::LANES :
                   tsf_pkg::SENSOR_COUNT);
        total   = 0;
        lo      = 0;
        hi      = 0;
        lo_lane = 0;
        hi_lane = 0;
        for (int i = 0; i < used; i++) begin
            q      = int'($signed(r[i]));
            whole  = clamp_degrees(q / 256);  // SV division truncates toward zero
            total += q;
            if (i == 0) begin
                lo = whole;
                hi = whole;
            end else begin
                if (whole < lo) begin
                    lo      = whole;
                    lo_lane = i;
                end
                if (whole > hi) begin
                    hi      = whole;
                    hi_lane = i;
                end
            end
        end
        avg  = clamp_degrees(total / (used * 256));
        sum8 = 8'(tsf_pkg::MODULE_NUMBER) + 8'(lo) + 8'(hi) + 8'(avg) + 8'(used)
             + 8'(lo_lane) + 8'(hi_lane) + tsf_pkg::CHECK_CONST;
        s.lowest       = tsf_pkg::deg_t'(lo);
        s.highest      = tsf_pkg::deg_t'(hi);
        s.mean         = tsf_pkg::deg_t'(avg);
        s.lowest_lane  = tsf_pkg::lane_idx_t'(lo_lane);
        s.highest_lane = tsf_pkg::lane_idx_t'(hi_lane);
        s.check        = sum8;
        return s;
    endfunction

    // Random readings: full range, clustered near zero for ties, all-equal, corner mixes
    function automatic reading_set_t random_readings();
        reading_set_t   r;
        int             mode;
        int             center;
        tsf_pkg::temp_t same;
        mode   = $urandom_range(0, 9);
        center = $urandom_range(0, 60) - 30;
        same   = tsf_pkg::temp_t'($urandom);
        for (int i = 0; i < tsf_pkg::LANES; i++) begin
            if (mode <= 3)
                r[i] = tsf_pkg::temp_t'($urandom);
            else if (mode <= 6)
                r[i] = tsf_pkg::temp_t'(center * 256 + $urandom_range(0, 1200) - 600);
            else if (mode == 7)
                r[i] = same;
            else
                r[i] = corner_values[$urandom_range(0, 7)];
        end
        return r;
    endfunction

    task automatic note_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    // Offer one item; called at a falling edge, returns at a falling edge
    task automatic offer_readings(input reading_set_t r, input logic typed,
                                  input summary_t want);
        while ($urandom_range(1, 100) <= tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_temp_lane0 <= r[0];
        s_temp_lane1 <= r[1];
        s_temp_lane2 <= r[2];
        s_temp_lane3 <= r[3];
        s_temp_lane4 <= r[4];
        s_temp_lane5 <= r[5];
        s_valid      <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_summaries.push_back(typed ? want : summarize_readings(r));
        @(negedge aclk);
    endtask

    // Stop sending until every expected result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_summaries.size() != 0);
    endtask

    // Receiver: random back-pressure plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(1, 100) > rx_idle_pct);
        end
    end

    // Result check against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_summaries.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result transfer with nothing expected");
            end else begin
                summary_t want;
                want = pending_summaries.pop_front();
                note_field("lowest_degrees", int'(want.lowest), int'(m_lowest_degrees));
                note_field("highest_degrees", int'(want.highest), int'(m_highest_degrees));
                note_field("mean_degrees", int'(want.mean), int'(m_mean_degrees));
                note_field("lowest_lane", int'(want.lowest_lane), int'(m_lowest_lane));
                note_field("highest_lane", int'(want.highest_lane), int'(m_highest_lane));
                note_field("frame_check", int'(want.check), int'(m_frame_check));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("** thermistor_summary_frame: FAILED **");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sender mostly busy, receiver often stalled
        tx_idle_pct = 16;
        rx_idle_pct = 53;
        foreach (directed_rows[i])
            offer_readings(directed_rows[i].readings, directed_rows[i].typed,
                           directed_rows[i].want);
        drain_results();
        repeat (PHASE_ONE) offer_readings(random_readings(), 1'b0, '0);

        // roles swapped
        tx_idle_pct = 53;
        rx_idle_pct = 16;
        repeat (PHASE_TWO) offer_readings(random_readings(), 1'b0, '0);
        drain_results();

        // no idling, with one long receiver hold-off to fill the pipeline
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(posedge aclk);
        hold_request = 1'b1;
        @(negedge aclk);
        repeat (PHASE_THREE) offer_readings(random_readings(), 1'b0, '0);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_summaries.size() == 0)
            $display("** thermistor_summary_frame: PASSED **");
        else
            $display("** thermistor_summary_frame: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tsf_pkg.sv
rtl/core/tsf_lane.sv
rtl/core/tsf_merge.sv
rtl/core/tsf_mean.sv
rtl/core/thermistor_summary_frame.sv
rtl/core/tsf_checker.sv
bench/thermistor_summary_frame_test.sv
